@@ hdl/brf_pkg.sv @@
// Shared types, codes and constants for the bilinear resize block.
`timescale 1ns / 1ps

package brf_pkg;

    // Default sizes handed to the top level parameters.
    localparam int DEF_MAX_WIDTH   = 256;
    localparam int DEF_MAX_HEIGHT  = 256;
    localparam int DEF_SAMPLE_BITS = 16;

    // Configuration registers.
    localparam int CFG_BITS     = 9;
    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_IN_WIDTH   = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_IN_HEIGHT  = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_OUT_WIDTH  = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_OUT_HEIGHT = CFG_IDX_BITS'(3);
    localparam logic [CFG_BITS-1:0] CFG_RESET   = CFG_BITS'(256);
    localparam logic [CFG_BITS-1:0] MIN_IN_SIZE = CFG_BITS'(2);

    // Item kinds carried in tuser bit 0.
    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_COMPUTE = 1'b1;

    // Fixed-point geometry of the position and weight math.
    localparam int IDX_BITS    = 8;
    localparam int FRAC_BITS   = 16;
    localparam int WGT_BITS    = FRAC_BITS + 1;
    localparam int NUM_BITS    = 2 * CFG_BITS;
    localparam int QUOT_BITS   = CFG_BITS + FRAC_BITS;
    localparam int HALF_SHIFT  = FRAC_BITS - 1;
    localparam int DIV_STEPS   = QUOT_BITS;
    localparam int DIV_PRE     = QUOT_BITS - HALF_SHIFT;
    localparam int PROD_BITS   = 2 * FRAC_BITS + 1;
    localparam int ACC_FRAC    = 2 * FRAC_BITS;
    localparam logic [WGT_BITS-1:0] WGT_ONE = WGT_BITS'(1) << FRAC_BITS;

    typedef struct packed {
        logic                 start;
        logic [NUM_BITS-1:0]  num;
        logic [CFG_BITS-1:0]  den;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic                 big;
        logic [QUOT_BITS-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic load_prod;
        logic acc_clear;
        logic acc_add;
    } mac_ctl_t;

endpackage

@@ hdl/brf_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module brf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/brf_div.sv @@
// Restoring divider, one quotient bit per cycle, for the Q16 source position.
`timescale 1ns / 1ps

module brf_div (
    input  logic              clk,
    input  logic              rst_n,
    input  brf_pkg::div_req_t req,
    output brf_pkg::div_rsp_t rsp
);

    localparam int CNT_BITS = $clog2(brf_pkg::DIV_STEPS + 1);
    localparam int QB = brf_pkg::QUOT_BITS;
    localparam int CB = brf_pkg::CFG_BITS;
    localparam int NB = brf_pkg::NUM_BITS;
    localparam int PB = brf_pkg::DIV_PRE;

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                big_reg, big_next;
    logic [CB-1:0]       rem_reg, rem_next;
    logic [QB-1:0]       sh_reg, sh_next;
    logic [CB:0]         trial;
    logic                fits;

    // The dividend is num * 2^15. Its top bits never produce a quotient bit
    // when the quotient stays below 2^25, so they seed the remainder.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        big_next  = big_reg;
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        trial     = {rem_reg, sh_reg[QB-1]};
        fits      = trial >= {1'b0, req.den};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(brf_pkg::DIV_STEPS);
            big_next  = {1'b0, req.num} >= {req.den, {PB{1'b0}}};
            rem_next  = CB'(req.num[NB-1:PB]);
            sh_next   = {req.num[PB-1:0], {(QB-PB){1'b0}}};
        end
        else if (busy_reg)
        begin
            rem_next = fits ? CB'(trial - {1'b0, req.den}) : trial[CB-1:0];
            sh_next  = {sh_reg[QB-2:0], fits};
            cnt_next = cnt_reg - CNT_BITS'(1);
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        big_reg <= big_next;
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
    end

    assign rsp.done = done_reg;
    assign rsp.big  = big_reg;
    assign rsp.quot = sh_reg;

endmodule

@@ hdl/brf_mac.sv @@
// Shared multiplier with a product register and a rounding accumulator.
`timescale 1ns / 1ps

module brf_mac #(
    parameter int SAMPLE_BITS = brf_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                   clk,
    input  brf_pkg::mac_ctl_t                      ctl,
    input  logic [((SAMPLE_BITS > brf_pkg::WGT_BITS) ?
                   SAMPLE_BITS : brf_pkg::WGT_BITS)-1:0] a,
    input  logic [brf_pkg::PROD_BITS-1:0]          b,
    output logic [brf_pkg::PROD_BITS-1:0]          prod,
    output logic [SAMPLE_BITS+brf_pkg::ACC_FRAC-1:0] acc
);

    localparam int A_BITS   = (SAMPLE_BITS > brf_pkg::WGT_BITS) ?
                              SAMPLE_BITS : brf_pkg::WGT_BITS;
    localparam int P_BITS   = brf_pkg::PROD_BITS;
    localparam int F_BITS   = A_BITS + P_BITS;
    localparam int ACC_BITS = SAMPLE_BITS + brf_pkg::ACC_FRAC;

    logic [F_BITS-1:0]   full;
    logic [P_BITS-1:0]   prod_reg;
    logic [ACC_BITS-1:0] acc_reg;

    assign full = F_BITS'(a) * F_BITS'(b);

    // The accumulator starts at one half of the final LSB so that the
    // closing shift rounds half up.
    always_ff @(posedge clk)
    begin
        if (ctl.load_prod)
        begin
            prod_reg <= full[P_BITS-1:0];
        end
        if (ctl.acc_clear)
        begin
            acc_reg <= {{SAMPLE_BITS{1'b0}}, 1'b1, {(brf_pkg::ACC_FRAC-1){1'b0}}};
        end
        else if (ctl.acc_add)
        begin
            acc_reg <= acc_reg + full[ACC_BITS-1:0];
        end
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

@@ hdl/bilinear_resize_forward.sv @@
// Bilinear resize of one plane: frame store, position divider and shared MAC.
// A load item is written to the store and the block stays ready for the next one.
// A compute item holds off the input while two serial 25-step divisions run,
// one per axis, then the four store reads and MACs that form its result.
// Reset clears the load pointer and sets all four size registers to 256.
`timescale 1ns / 1ps

module bilinear_resize_forward #(
    parameter int MAX_WIDTH   = brf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = brf_pkg::DEF_MAX_HEIGHT,
    parameter int SAMPLE_BITS = brf_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_tvalid,
    output logic                                  in_tready,
    // sample_in, out_row, out_col, zero padding
    input  logic [((SAMPLE_BITS+23)/8)*8-1:0]     in_tdata,
    // operation, start_of_frame
    input  logic [1:0]                            in_tuser,
    output logic                                  out_tvalid,
    input  logic                                  out_tready,
    // pixel_out, zero padding
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]      out_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [brf_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [brf_pkg::CFG_BITS-1:0]          cfg_data
);

    localparam int SB      = SAMPLE_BITS;
    localparam int OUT_DW  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW      = $clog2(DEPTH);
    localparam int SW      = (AW > brf_pkg::NUM_BITS + 1) ? AW : brf_pkg::NUM_BITS + 1;
    localparam int CB      = brf_pkg::CFG_BITS;
    localparam int IB      = brf_pkg::IDX_BITS;
    localparam int WB      = brf_pkg::WGT_BITS;
    localparam int FB      = brf_pkg::FRAC_BITS;
    localparam int QB      = brf_pkg::QUOT_BITS;
    localparam int PB      = brf_pkg::PROD_BITS;
    localparam int A_BITS  = (SB > WB) ? SB : WB;
    localparam int ACC_BITS = SB + brf_pkg::ACC_FRAC;
    localparam int CLAMP_W = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
    localparam int CLAMP_H = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL    = 4'd1;
    localparam logic [3:0] S_DSTART = 4'd2;
    localparam logic [3:0] S_DWAIT  = 4'd3;
    localparam logic [3:0] S_BASE   = 4'd4;
    localparam logic [3:0] S_ADDR   = 4'd5;
    localparam logic [3:0] S_WGT    = 4'd6;
    localparam logic [3:0] S_ACC    = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;

    logic [3:0]    state_reg, state_next;
    logic          axis_reg, axis_next;
    logic [1:0]    k_reg, k_next;
    logic          out_valid_reg, out_valid_next;
    logic [AW-1:0] load_ptr_reg, load_ptr_next;
    logic [CB-1:0] in_width_reg, in_height_reg, out_width_reg, out_height_reg;

    logic [IB-1:0] row_reg, col_reg;
    logic [CB-1:0] x_reg, y_reg;
    logic [WB-1:0] wx_reg, wy_reg;
    logic [SW-1:0] base_reg;
    logic [SB-1:0] pixel_reg;

    logic [CB-1:0] iw_c, ih_c, ow_c, oh_c;
    logic [CB-1:0] ax_in, ax_out, fac;
    logic [IB-1:0] ax_idx;
    logic          sat;
    logic [CB-1:0] pos_idx;
    logic [WB-1:0] pos_wgt;
    logic [WB-1:0] wyk, wxk;
    logic [SW-1:0] rd_addr_w;

    logic          in_acc, load_acc, comp_acc, out_acc;
    logic [SB-1:0] sample;
    logic [AW-1:0] wr_addr;
    logic [SB-1:0] rd_data;
    logic          rd_en;

    brf_pkg::div_req_t div_req;
    brf_pkg::div_rsp_t div_rsp;
    brf_pkg::mac_ctl_t mac_ctl;
    logic [A_BITS-1:0]   mac_a;
    logic [PB-1:0]       mac_b;
    logic [PB-1:0]       mac_prod;
    logic [ACC_BITS-1:0] mac_acc;
    logic [SB-1:0]       rounded;

    assign in_tready  = (state_reg == S_IDLE);
    assign in_acc     = in_tvalid && in_tready;
    assign load_acc   = in_acc && (in_tuser[0] == brf_pkg::OP_LOAD);
    assign comp_acc   = in_acc && (in_tuser[0] == brf_pkg::OP_COMPUTE);
    assign out_acc    = out_tvalid && out_tready;
    assign out_tvalid = out_valid_reg;
    assign out_tdata  = OUT_DW'(pixel_reg);
    assign cfg_ready  = 1'b1;

    // Samples are kept in offset binary: flipping the sign bit adds half range.
    assign sample  = {~in_tdata[SB-1], in_tdata[SB-2:0]};
    assign wr_addr = in_tuser[1] ? '0 : load_ptr_reg;

    always_comb
    begin
        iw_c = (in_width_reg < brf_pkg::MIN_IN_SIZE) ? brf_pkg::MIN_IN_SIZE :
               (in_width_reg > CB'(CLAMP_W)) ? CB'(CLAMP_W) : in_width_reg;
        ih_c = (in_height_reg < brf_pkg::MIN_IN_SIZE) ? brf_pkg::MIN_IN_SIZE :
               (in_height_reg > CB'(CLAMP_H)) ? CB'(CLAMP_H) : in_height_reg;
        ow_c = (out_width_reg == '0) ? CB'(1) : out_width_reg;
        oh_c = (out_height_reg == '0) ? CB'(1) : out_height_reg;
    end

    // Per-axis operands; the axis bit selects columns first, then rows.
    always_comb
    begin
        ax_in   = axis_reg ? ih_c : iw_c;
        ax_out  = axis_reg ? oh_c : ow_c;
        ax_idx  = axis_reg ? row_reg : col_reg;
        fac     = (ax_idx == '0) ? '0 : {ax_idx, 1'b0} - CB'(1);
        sat     = div_rsp.big || (div_rsp.quot >= {ax_in - CB'(1), {FB{1'b0}}});
        pos_idx = sat ? ax_in - brf_pkg::MIN_IN_SIZE : div_rsp.quot[QB-1:FB];
        pos_wgt = sat ? '0 : brf_pkg::WGT_ONE - {1'b0, div_rsp.quot[FB-1:0]};
    end

    // Neighbor k: bit 0 picks the right column, bit 1 the lower row.
    always_comb
    begin
        wyk       = k_reg[1] ? brf_pkg::WGT_ONE - wy_reg : wy_reg;
        wxk       = k_reg[0] ? brf_pkg::WGT_ONE - wx_reg : wx_reg;
        rd_addr_w = base_reg + (k_reg[1] ? SW'(iw_c) : '0) + SW'(k_reg[0]);
    end

    assign rounded = mac_acc[ACC_BITS-1:brf_pkg::ACC_FRAC];

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg && !out_acc;
        load_ptr_next  = load_ptr_reg;
        div_req.start  = 1'b0;
        div_req.num    = mac_prod[brf_pkg::NUM_BITS-1:0];
        div_req.den    = ax_out;
        mac_ctl        = '0;
        mac_a          = '0;
        mac_b          = '0;
        rd_en          = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (load_acc)
                begin
                    load_ptr_next = (wr_addr == AW'(DEPTH - 1)) ? '0 : wr_addr + AW'(1);
                end
                if (comp_acc)
                begin
                    axis_next  = 1'b0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                mac_ctl.load_prod = 1'b1;
                mac_a             = A_BITS'(ax_in);
                mac_b             = PB'(fac);
                state_next        = S_DSTART;
            end
            S_DSTART:
            begin
                div_req.start = 1'b1;
                state_next    = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (div_rsp.done)
                begin
                    axis_next  = 1'b1;
                    state_next = axis_reg ? S_BASE : S_MUL;
                end
            end
            S_BASE:
            begin
                mac_ctl.load_prod = 1'b1;
                mac_ctl.acc_clear = 1'b1;
                mac_a             = A_BITS'(y_reg);
                mac_b             = PB'(iw_c);
                k_next            = '0;
                state_next        = S_ADDR;
            end
            S_ADDR:
            begin
                state_next = S_WGT;
            end
            S_WGT:
            begin
                rd_en             = 1'b1;
                mac_ctl.load_prod = 1'b1;
                mac_a             = A_BITS'(wyk);
                mac_b             = PB'(wxk);
                state_next        = S_ACC;
            end
            S_ACC:
            begin
                mac_ctl.acc_add = 1'b1;
                mac_a           = A_BITS'(rd_data);
                mac_b           = mac_prod;
                k_next          = k_reg + 2'd1;
                state_next      = (k_reg == 2'd3) ? S_FIN : S_WGT;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_tready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            axis_reg       <= 1'b0;
            k_reg          <= '0;
            out_valid_reg  <= 1'b0;
            load_ptr_reg   <= '0;
            in_width_reg   <= brf_pkg::CFG_RESET;
            in_height_reg  <= brf_pkg::CFG_RESET;
            out_width_reg  <= brf_pkg::CFG_RESET;
            out_height_reg <= brf_pkg::CFG_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            load_ptr_reg  <= load_ptr_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    brf_pkg::REG_IN_WIDTH:   in_width_reg   <= cfg_data;
                    brf_pkg::REG_IN_HEIGHT:  in_height_reg  <= cfg_data;
                    brf_pkg::REG_OUT_WIDTH:  out_width_reg  <= cfg_data;
                    brf_pkg::REG_OUT_HEIGHT: out_height_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (comp_acc)
        begin
            row_reg <= in_tdata[SB+IB-1:SB];
            col_reg <= in_tdata[SB+2*IB-1:SB+IB];
        end
        if (state_reg == S_DWAIT && div_rsp.done)
        begin
            if (axis_reg)
            begin
                y_reg  <= pos_idx;
                wy_reg <= pos_wgt;
            end
            else
            begin
                x_reg  <= pos_idx;
                wx_reg <= pos_wgt;
            end
        end
        if (state_reg == S_ADDR)
        begin
            base_reg <= SW'(mac_prod[brf_pkg::NUM_BITS-1:0]) + SW'(x_reg);
        end
        if (state_reg == S_FIN && (!out_valid_reg || out_tready))
        begin
            pixel_reg <= {~rounded[SB-1], rounded[SB-2:0]};
        end
    end

    brf_ram #(
        .WIDTH (SB),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (load_acc),
        .wr_addr (wr_addr),
        .wr_data (sample),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_w[AW-1:0]),
        .rd_data (rd_data)
    );

    brf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    brf_mac #(
        .SAMPLE_BITS (SB)
    ) u_mac (
        .clk  (clk),
        .ctl  (mac_ctl),
        .a    (mac_a),
        .b    (mac_b),
        .prod (mac_prod),
        .acc  (mac_acc)
    );

endmodule

@@ hdl/brf_checker.sv @@
// Port-level checks for the bilinear resize block and their bind.
`timescale 1ns / 1ps

module brf_checker #(
    parameter int SAMPLE_BITS = brf_pkg::DEF_SAMPLE_BITS
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_tvalid,
    input logic                                 in_tready,
    input logic [1:0]                           in_tuser,
    input logic                                 out_tvalid,
    input logic                                 out_tready,
    input logic [((SAMPLE_BITS+7)/8)*8-1:0]     out_tdata
);

    // A stalled result transfer keeps its data.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
        else $error("result changed while stalled");

    // A compute item occupies the sequencer.
    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_tvalid && in_tready && (in_tuser[0] == brf_pkg::OP_COMPUTE) |=> !in_tready)
        else $error("input taken while a compute is running");

    // A load completes in its own cycle.
    a_load_single: assert property (@(posedge clk) disable iff (!rst_n)
        in_tvalid && in_tready && (in_tuser[0] == brf_pkg::OP_LOAD) |=> in_tready)
        else $error("load stalled the input");

    // No result is pending right after reset.
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_tvalid)
        else $error("result valid out of reset");

endmodule

bind bilinear_resize_forward brf_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_brf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
);
